[hdl/ctf_pkg.sv]
package ctf_pkg;

	// Default geometry of the datapath.
	localparam int COORD_BITS       = 10;
	localparam int CENTER_BITS      = 24;
	localparam int RADIUS_FRAC_BITS = 4;

	// The radius field is fixed at 28 bits whatever the fraction width.
	localparam int RADIUS_WIDTH = 28;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int RADIUS_REG_W = 16;
	localparam int SIZE_REG_W   = 11;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RADIUS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 2'd3;

	// Radius window after reset: 5.0 and 8.0 pixels with four fraction bits.
	localparam logic [RADIUS_REG_W-1:0] MIN_RADIUS_RESET = 16'd80;
	localparam logic [RADIUS_REG_W-1:0] MAX_RADIUS_RESET = 16'd128;
	localparam logic [SIZE_REG_W-1:0]   IMAGE_SIZE_RESET = 11'd1024;

	// Side flags that ride along with the two center quotients.
	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic collinear;
	} ctf_div_flags_t;

	// Side flags that ride along with the radius root.
	typedef struct packed {
		logic saturated;
		logic collinear;
		logic overflow;
	} ctf_rad_flags_t;

endpackage

[hdl/ctf_if.sv]
interface ctf_pts_if #(parameter int COORD_BITS = ctf_pkg::COORD_BITS);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] first_x;
	logic [COORD_BITS-1:0] first_y;
	logic [COORD_BITS-1:0] second_x;
	logic [COORD_BITS-1:0] second_y;
	logic [COORD_BITS-1:0] third_x;
	logic [COORD_BITS-1:0] third_y;

	modport source(output valid, first_x, first_y, second_x, second_y, third_x, third_y,
		input ready);
	modport sink(input valid, first_x, first_y, second_x, second_y, third_x, third_y,
		output ready);
endinterface

interface ctf_circle_if #(parameter int CENTER_BITS = ctf_pkg::CENTER_BITS);
	logic                                  valid;
	logic                                  ready;
	logic signed [CENTER_BITS-1:0]         center_x;
	logic signed [CENTER_BITS-1:0]         center_y;
	logic [ctf_pkg::RADIUS_WIDTH-1:0]      radius_q4;
	logic                                  collinear;
	logic                                  saturated;
	logic                                  accepted;

	modport source(output valid, center_x, center_y, radius_q4, collinear, saturated,
		accepted, input ready);
	modport sink(input valid, center_x, center_y, radius_q4, collinear, saturated,
		accepted, output ready);
endinterface

interface ctf_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [ctf_pkg::CFG_IDX_W-1:0]   index;
	logic [ctf_pkg::CFG_DATA_W-1:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[hdl/three_point_circle_fit.sv]
// Channel  | Dir | Handshake    | Contents
// pts      | in  | valid/ready  | three points, first_x .. third_y
// circle   | out | valid/ready  | center_x, center_y, radius_q4, collinear, saturated, accepted
// cfg      | in  | valid/ready  | register index and write data, ready always high
//
// One request enters per cycle while the output is not held; a result passes
// through the one-bit-per-stage center divider and the one-bit-per-stage
// radius root. arst_n clears all valid bits and loads the register reset
// values. When the output register holds a result that is not taken, the
// whole pipeline holds and pts.ready drops; nothing is lost.
module three_point_circle_fit #(
	parameter int COORD_BITS       = ctf_pkg::COORD_BITS,
	parameter int CENTER_BITS      = ctf_pkg::CENTER_BITS,
	parameter int RADIUS_FRAC_BITS = ctf_pkg::RADIUS_FRAC_BITS
) (
	input logic           clk,
	input logic           arst_n,
	ctf_pts_if.sink       pts,
	ctf_circle_if.source  circle,
	ctf_cfg_if.sink       cfg
);

	localparam int CW = COORD_BITS;
	localparam int CB = CENTER_BITS;
	localparam int F  = RADIUS_FRAC_BITS;
	localparam int RW = ctf_pkg::RADIUS_WIDTH;
	localparam int SW = ctf_pkg::SIZE_REG_W;
	localparam int RRW = ctf_pkg::RADIUS_REG_W;

	// Twice the determinant and the two center numerators, signed.
	localparam int DW = 2*CW + 5;
	localparam int PW = 2*CW + 2;
	localparam int MW = 3*CW + 3;
	localparam int NW = 3*CW + 5;
	// Room for a signed quotient next to the clip limits.
	localparam int EW = ((NW > CB) ? NW : CB) + 2;
	// Center minus first point, and that distance with room for the limit test.
	localparam int AW  = ((CB > CW + 1) ? CB : CW + 1) + 2;
	localparam int AXW = (AW > RW + 2) ? AW : RW + 2;
	// Acceptance comparisons with the center scaled by the fraction bits.
	localparam int TW0 = (CB + F > RW + 1) ? CB + F : RW + 1;
	localparam int TW  = ((TW0 > SW + F) ? TW0 : SW + F) + 2;
	localparam int DTAG_W = 3 + 2*CW;
	localparam int RTAG_W = 3 + 2*CB;

	localparam logic signed [EW-1:0] CLIP_HI = {{(EW-CB+1){1'b0}}, {(CB-1){1'b1}}};
	localparam logic signed [EW-1:0] CLIP_LO = ~CLIP_HI;
	localparam logic [AXW-1:0] AX_LIMIT = {{(AXW-RW-1){1'b0}}, 1'b1, {RW{1'b0}}};

	// The whole pipeline advances unless the output register is held.
	logic adv;

	// Configuration registers.
	logic [RRW-1:0] min_radius_q, max_radius_q;
	logic [SW-1:0]  image_cols_q, image_rows_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_radius_q <= ctf_pkg::MIN_RADIUS_RESET;
			max_radius_q <= ctf_pkg::MAX_RADIUS_RESET;
			image_cols_q <= ctf_pkg::IMAGE_SIZE_RESET;
			image_rows_q <= ctf_pkg::IMAGE_SIZE_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ctf_pkg::REG_MIN_RADIUS: min_radius_q <= cfg.data[RRW-1:0];
				ctf_pkg::REG_MAX_RADIUS: max_radius_q <= cfg.data[RRW-1:0];
				ctf_pkg::REG_IMAGE_COLS: image_cols_q <= cfg.data[SW-1:0];
				ctf_pkg::REG_IMAGE_ROWS: image_rows_q <= cfg.data[SW-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1: coordinate differences, squared norms and determinant products.
	logic signed [CW:0]   x1e, y1e, x2e, y2e, x3e, y3e;
	logic [2*CW:0]        x1w, y1w, x2w, y2w, x3w, y3w;
	logic                 vld_s1;
	logic [CW-1:0]        x1_s1, y1_s1;
	logic [2*CW:0]        sq1_s1, sq2_s1, sq3_s1;
	logic signed [CW:0]   dy23_s1, dy31_s1, dy12_s1, dx32_s1, dx13_s1, dx21_s1;
	logic signed [PW-1:0] pd1_s1, pd2_s1, pd3_s1, pd4_s1;

	assign x1e = $signed({1'b0, pts.first_x});
	assign y1e = $signed({1'b0, pts.first_y});
	assign x2e = $signed({1'b0, pts.second_x});
	assign y2e = $signed({1'b0, pts.second_y});
	assign x3e = $signed({1'b0, pts.third_x});
	assign y3e = $signed({1'b0, pts.third_y});
	assign x1w = (2*CW+1)'(pts.first_x);
	assign y1w = (2*CW+1)'(pts.first_y);
	assign x2w = (2*CW+1)'(pts.second_x);
	assign y2w = (2*CW+1)'(pts.second_y);
	assign x3w = (2*CW+1)'(pts.third_x);
	assign y3w = (2*CW+1)'(pts.third_y);

	assign pts.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pts.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s1   <= pts.first_x;
			y1_s1   <= pts.first_y;
			sq1_s1  <= x1w * x1w + y1w * y1w;
			sq2_s1  <= x2w * x2w + y2w * y2w;
			sq3_s1  <= x3w * x3w + y3w * y3w;
			dy23_s1 <= y2e - y3e;
			dy31_s1 <= y3e - y1e;
			dy12_s1 <= y1e - y2e;
			dx32_s1 <= x3e - x2e;
			dx13_s1 <= x1e - x3e;
			dx21_s1 <= x2e - x1e;
			pd1_s1  <= x1e * (y2e - y3e);
			pd2_s1  <= y1e * (x2e - x3e);
			pd3_s1  <= x2e * y3e;
			pd4_s1  <= x3e * y2e;
		end
	end

	// Stage 2: the determinant and the six numerator products.
	logic signed [MW-1:0] s1e_unused_guard;
	logic signed [PW-1:0] sq1e, sq2e, sq3e;
	logic                 vld_s2;
	logic [CW-1:0]        x1_s2, y1_s2;
	logic signed [DW-1:0] d_s2;
	logic signed [MW-1:0] npx1_s2, npx2_s2, npx3_s2, npy1_s2, npy2_s2, npy3_s2;

	assign sq1e = $signed({1'b0, sq1_s1});
	assign sq2e = $signed({1'b0, sq2_s1});
	assign sq3e = $signed({1'b0, sq3_s1});
	assign s1e_unused_guard = sq1e * dy23_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s2   <= x1_s1;
			y1_s2   <= y1_s1;
			d_s2    <= (DW'(pd1_s1) - DW'(pd2_s1) + DW'(pd3_s1) - DW'(pd4_s1)) <<< 1;
			npx1_s2 <= s1e_unused_guard;
			npx2_s2 <= sq2e * dy31_s1;
			npx3_s2 <= sq3e * dy12_s1;
			npy1_s2 <= sq1e * dx32_s1;
			npy2_s2 <= sq2e * dx13_s1;
			npy3_s2 <= sq3e * dx21_s1;
		end
	end

	// Stage 3: numerator sums.
	logic                 vld_s3;
	logic [CW-1:0]        x1_s3, y1_s3;
	logic signed [DW-1:0] d_s3;
	logic signed [NW-1:0] nx_s3, ny_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s3 <= x1_s2;
			y1_s3 <= y1_s2;
			d_s3  <= d_s2;
			nx_s3 <= NW'(npx1_s2) + NW'(npx2_s2) + NW'(npx3_s2);
			ny_s3 <= NW'(npy1_s2) + NW'(npy2_s2) + NW'(npy3_s2);
		end
	end

	// Stage 4: magnitudes and quotient signs; the quotient truncates toward
	// zero, so it is the magnitude quotient with the combined sign.
	logic                    vld_s4;
	logic [CW-1:0]           x1_s4, y1_s4;
	logic [NW-1:0]           nxm_s4, nym_s4;
	logic [DW-1:0]           dm_s4;
	ctf_pkg::ctf_div_flags_t dflags_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s4               <= x1_s3;
			y1_s4               <= y1_s3;
			nxm_s4              <= nx_s3[NW-1] ? NW'(-nx_s3) : NW'(nx_s3);
			nym_s4              <= ny_s3[NW-1] ? NW'(-ny_s3) : NW'(ny_s3);
			dm_s4               <= d_s3[DW-1] ? DW'(-d_s3) : DW'(d_s3);
			dflags_s4.neg_x     <= nx_s3[NW-1] ^ d_s3[DW-1];
			dflags_s4.neg_y     <= ny_s3[NW-1] ^ d_s3[DW-1];
			dflags_s4.collinear <= (d_s3 == '0);
		end
	end

	// Center divider, NW stages.
	logic                    div_vld;
	logic [NW-1:0]           quo_x, quo_y;
	logic [DTAG_W-1:0]       div_tag;
	ctf_pkg::ctf_div_flags_t dflags_o;
	logic [CW-1:0]           div_x1, div_y1;

	ctf_div #(
		.NUM_W(NW),
		.DEN_W(DW),
		.TAG_W(DTAG_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_in (vld_s4),
		.num_a  (nxm_s4),
		.num_b  (nym_s4),
		.den    (dm_s4),
		.tag_in ({dflags_s4, x1_s4, y1_s4}),
		.vld_out(div_vld),
		.quo_a  (quo_x),
		.quo_b  (quo_y),
		.tag_out(div_tag)
	);

	assign {dflags_o, div_x1, div_y1} = div_tag;

	// Stage 5: sign and clip the centers.
	logic signed [EW-1:0] qxm, qym, qx, qy, cxc, cyc;
	logic                 vld_s5, sat_s5, coll_s5;
	logic [CW-1:0]        x1_s5, y1_s5;
	logic signed [CB-1:0] cx_s5, cy_s5;

	assign qxm = $signed({{(EW-NW){1'b0}}, quo_x});
	assign qym = $signed({{(EW-NW){1'b0}}, quo_y});
	assign qx  = dflags_o.neg_x ? -qxm : qxm;
	assign qy  = dflags_o.neg_y ? -qym : qym;
	assign cxc = (qx > CLIP_HI) ? CLIP_HI : ((qx < CLIP_LO) ? CLIP_LO : qx);
	assign cyc = (qy > CLIP_HI) ? CLIP_HI : ((qy < CLIP_LO) ? CLIP_LO : qy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s5   <= div_x1;
			y1_s5   <= div_y1;
			cx_s5   <= cxc[CB-1:0];
			cy_s5   <= cyc[CB-1:0];
			sat_s5  <= (qx > CLIP_HI) || (qx < CLIP_LO) || (qy > CLIP_HI) || (qy < CLIP_LO);
			coll_s5 <= dflags_o.collinear;
		end
	end

	// Stage 6: distance from the integer center to the first point. A leg
	// longer than the radius range forces the radius to its maximum.
	logic signed [AW-1:0] ddx, ddy;
	logic [AXW-1:0]       adx, ady;
	logic                 vld_s6, sat_s6, coll_s6, big_s6;
	logic signed [CB-1:0] cx_s6, cy_s6;
	logic [RW:0]          ax_s6, ay_s6;

	assign ddx = AW'(cx_s5) - $signed({{(AW-CW){1'b0}}, x1_s5});
	assign ddy = AW'(cy_s5) - $signed({{(AW-CW){1'b0}}, y1_s5});
	assign adx = AXW'(ddx[AW-1] ? $unsigned(-ddx) : $unsigned(ddx));
	assign ady = AXW'(ddy[AW-1] ? $unsigned(-ddy) : $unsigned(ddy));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s6   <= cx_s5;
			cy_s6   <= cy_s5;
			sat_s6  <= sat_s5;
			coll_s6 <= coll_s5;
			big_s6  <= (adx > AX_LIMIT) || (ady > AX_LIMIT);
			ax_s6   <= adx[RW:0];
			ay_s6   <= ady[RW:0];
		end
	end

	// Stage 7: squared legs.
	logic                 vld_s7, sat_s7, coll_s7, big_s7;
	logic signed [CB-1:0] cx_s7, cy_s7;
	logic [2*RW+1:0]      sqx_s7, sqy_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s7   <= cx_s6;
			cy_s7   <= cy_s6;
			sat_s7  <= sat_s6;
			coll_s7 <= coll_s6;
			big_s7  <= big_s6;
			sqx_s7  <= (2*RW+2)'(ax_s6) * (2*RW+2)'(ax_s6);
			sqy_s7  <= (2*RW+2)'(ay_s6) * (2*RW+2)'(ay_s6);
		end
	end

	// Stage 8: squared distance, overflow test and scaling by the fraction bits.
	logic [2*RW+2:0]         d2, d2_sh;
	logic                    vld_s8;
	logic signed [CB-1:0]    cx_s8, cy_s8;
	logic [2*RW-1:0]         rad_s8;
	ctf_pkg::ctf_rad_flags_t rflags_s8;

	assign d2    = (2*RW+3)'(sqx_s7) + (2*RW+3)'(sqy_s7);
	assign d2_sh = d2 << (2*F);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s8               <= cx_s7;
			cy_s8               <= cy_s7;
			rad_s8              <= d2_sh[2*RW-1:0];
			rflags_s8.saturated <= sat_s7;
			rflags_s8.collinear <= coll_s7;
			rflags_s8.overflow  <= big_s7 || ((d2 >> (2*RW - 2*F)) != '0);
		end
	end

	// Radius root, RW stages.
	logic                    sq_vld;
	logic [RW-1:0]           root;
	logic [RTAG_W-1:0]       sq_tag;
	ctf_pkg::ctf_rad_flags_t rflags_o;
	logic signed [CB-1:0]    sq_cx, sq_cy;

	ctf_isqrt #(
		.ROOT_W(RW),
		.TAG_W (RTAG_W)
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.vld_in  (vld_s8),
		.radicand(rad_s8),
		.tag_in  ({rflags_s8, cx_s8, cy_s8}),
		.vld_out (sq_vld),
		.root    (root),
		.tag_out (sq_tag)
	);

	assign {rflags_o, sq_cx, sq_cy} = sq_tag;

	// Stage 9, the output register: radius window and in-image test.
	logic [RW-1:0]        rad_f;
	logic signed [TW-1:0] cxs, cys, rs, cols_s, rows_s;
	logic                 ok;
	logic                 vld_s9, coll_s9, sat_s9, acc_s9;
	logic signed [CB-1:0] cx_s9, cy_s9;
	logic [RW-1:0]        rad_s9;

	assign rad_f  = rflags_o.overflow ? {RW{1'b1}} : root;
	assign cxs    = TW'(sq_cx) <<< F;
	assign cys    = TW'(sq_cy) <<< F;
	assign rs     = $signed({{(TW-RW){1'b0}}, rad_f});
	assign cols_s = $signed({{(TW-SW){1'b0}}, image_cols_q}) <<< F;
	assign rows_s = $signed({{(TW-SW){1'b0}}, image_rows_q}) <<< F;
	assign ok     = (rad_f >= RW'(min_radius_q)) && (rad_f <= RW'(max_radius_q))
		&& (cxs > rs) && (cys > rs) && (cxs + rs < cols_s) && (cys + rs < rows_s);

	assign adv = !vld_s9 || circle.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (adv) begin
			vld_s9 <= sq_vld;
		end
	end

	// Collinear points give zeros everywhere but the flag.
	always_ff @(posedge clk) begin
		if (adv) begin
			coll_s9 <= rflags_o.collinear;
			cx_s9   <= rflags_o.collinear ? '0 : sq_cx;
			cy_s9   <= rflags_o.collinear ? '0 : sq_cy;
			rad_s9  <= rflags_o.collinear ? '0 : rad_f;
			sat_s9  <= rflags_o.saturated && !rflags_o.collinear;
			acc_s9  <= ok && !rflags_o.collinear;
		end
	end

	assign circle.valid     = vld_s9;
	assign circle.center_x  = cx_s9;
	assign circle.center_y  = cy_s9;
	assign circle.radius_q4 = rad_s9;
	assign circle.collinear = coll_s9;
	assign circle.saturated = sat_s9;
	assign circle.accepted  = acc_s9;

endmodule

[hdl/ctf_div.sv]
// Pipelined restoring divider: one quotient bit per stage, two numerators
// sharing one divisor. Operands are magnitudes.
module ctf_div #(
	parameter int NUM_W = 35,
	parameter int DEN_W = 25,
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  logic [NUM_W-1:0] num_a,
	input  logic [NUM_W-1:0] num_b,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] tag_in,
	output logic             vld_out,
	output logic [NUM_W-1:0] quo_a,
	output logic [NUM_W-1:0] quo_b,
	output logic [TAG_W-1:0] tag_out
);

	logic             vld_s   [0:NUM_W];
	logic [DEN_W-1:0] rem_a_s [0:NUM_W];
	logic [DEN_W-1:0] rem_b_s [0:NUM_W];
	logic [NUM_W-1:0] div_a_s [0:NUM_W];
	logic [NUM_W-1:0] div_b_s [0:NUM_W];
	logic [DEN_W-1:0] den_s   [0:NUM_W];
	logic [TAG_W-1:0] tag_s   [0:NUM_W];

	assign vld_s[0]   = vld_in;
	assign rem_a_s[0] = '0;
	assign rem_b_s[0] = '0;
	assign div_a_s[0] = num_a;
	assign div_b_s[0] = num_b;
	assign den_s[0]   = den;
	assign tag_s[0]   = tag_in;

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [DEN_W:0] trial_a, trial_b, diff_a, diff_b;
		logic           ge_a, ge_b;

		// The running remainder takes the next dividend bit from the top.
		assign trial_a = {rem_a_s[k], div_a_s[k][NUM_W-1]};
		assign trial_b = {rem_b_s[k], div_b_s[k][NUM_W-1]};
		assign diff_a  = trial_a - {1'b0, den_s[k]};
		assign diff_b  = trial_b - {1'b0, den_s[k]};
		assign ge_a    = trial_a >= {1'b0, den_s[k]};
		assign ge_b    = trial_b >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_a_s[k+1] <= ge_a ? diff_a[DEN_W-1:0] : trial_a[DEN_W-1:0];
				rem_b_s[k+1] <= ge_b ? diff_b[DEN_W-1:0] : trial_b[DEN_W-1:0];
				div_a_s[k+1] <= {div_a_s[k][NUM_W-2:0], ge_a};
				div_b_s[k+1] <= {div_b_s[k][NUM_W-2:0], ge_b};
				den_s[k+1]   <= den_s[k];
				tag_s[k+1]   <= tag_s[k];
			end
		end
	end

	assign vld_out = vld_s[NUM_W];
	assign quo_a   = div_a_s[NUM_W];
	assign quo_b   = div_b_s[NUM_W];
	assign tag_out = tag_s[NUM_W];

endmodule

[hdl/ctf_isqrt.sv]
// Pipelined digit-by-digit integer square root, one root bit per stage.
module ctf_isqrt #(
	parameter int ROOT_W = 28,
	parameter int TAG_W  = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  vld_in,
	input  logic [2*ROOT_W-1:0]   radicand,
	input  logic [TAG_W-1:0]      tag_in,
	output logic                  vld_out,
	output logic [ROOT_W-1:0]     root,
	output logic [TAG_W-1:0]      tag_out
);

	logic                vld_s  [0:ROOT_W];
	logic [ROOT_W:0]     rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0]   root_s [0:ROOT_W];
	logic [2*ROOT_W-1:0] rad_s  [0:ROOT_W];
	logic [TAG_W-1:0]    tag_s  [0:ROOT_W];

	assign vld_s[0]  = vld_in;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = radicand;
	assign tag_s[0]  = tag_in;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic [ROOT_W+2:0] cur, trial, diff;
		logic              ge;

		// Bring down the next two radicand bits and try the next root bit.
		assign cur   = {rem_s[k], rad_s[k][2*ROOT_W-1 -: 2]};
		assign trial = {1'b0, root_s[k], 2'b01};
		assign diff  = cur - trial;
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[ROOT_W:0] : cur[ROOT_W:0];
				root_s[k+1] <= {root_s[k][ROOT_W-2:0], ge};
				rad_s[k+1]  <= {rad_s[k][2*ROOT_W-3:0], 2'b00};
				tag_s[k+1]  <= tag_s[k];
			end
		end
	end

	assign vld_out = vld_s[ROOT_W];
	assign root    = root_s[ROOT_W];
	assign tag_out = tag_s[ROOT_W];

endmodule

[hdl/ctf_checker.sv]
module ctf_checker #(
	parameter int CENTER_BITS = ctf_pkg::CENTER_BITS
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [CENTER_BITS-1:0]    center_x,
	input logic signed [CENTER_BITS-1:0]    center_y,
	input logic [ctf_pkg::RADIUS_WIDTH-1:0] radius_q4,
	input logic                             collinear,
	input logic                             saturated,
	input logic                             accepted
);

	localparam logic signed [CENTER_BITS-1:0] C_MAX = {1'b0, {(CENTER_BITS-1){1'b1}}};
	localparam logic signed [CENTER_BITS-1:0] C_MIN = {1'b1, {(CENTER_BITS-1){1'b0}}};

	// A result waiting at the output is not withdrawn.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// Collinear points carry no circle.
	a_collinear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && collinear |-> center_x == '0 && center_y == '0
			&& radius_q4 == '0 && !saturated && !accepted)
		else $error("collinear result carries a circle");

	// A circle that fits the image is not collinear and cannot have a clipped center.
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> !collinear && !saturated)
		else $error("accepted circle is collinear or clipped");

	// A clip flag means some center coordinate sits on a range limit.
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> center_x == C_MAX || center_x == C_MIN
			|| center_y == C_MAX || center_y == C_MIN)
		else $error("clip flag without a clipped center");

endmodule

bind three_point_circle_fit ctf_checker #(
	.CENTER_BITS(CENTER_BITS)
) u_ctf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(circle.valid),
	.out_ready(circle.ready),
	.center_x (circle.center_x),
	.center_y (circle.center_y),
	.radius_q4(circle.radius_q4),
	.collinear(circle.collinear),
	.saturated(circle.saturated),
	.accepted (circle.accepted)
);

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

	// Pipeline depth at the default sizes; drain adds a margin on top of it.
	localparam int PIPE_LAT  = 3 * ctf_pkg::COORD_BITS + 42;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [ctf_pkg::COORD_BITS-1:0] x1, y1, x2, y2, x3, y3;
	} triple_t;

	typedef struct packed {
		logic signed [ctf_pkg::CENTER_BITS-1:0] cx;
		logic signed [ctf_pkg::CENTER_BITS-1:0] cy;
		logic [ctf_pkg::RADIUS_WIDTH-1:0]       r;
		logic                                   col;
		logic                                   sat;
		logic                                   acc;
	} circle_t;

	logic clk;
	logic arst_n;

	ctf_pts_if    pts();
	ctf_circle_if circle();
	ctf_cfg_if    cfg();

	three_point_circle_fit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pts    (pts),
		.circle (circle),
		.cfg    (cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the configuration registers.
	logic [ctf_pkg::RADIUS_REG_W-1:0] win_min, win_max;
	logic [ctf_pkg::SIZE_REG_W-1:0]   img_cols, img_rows;

	circle_t expected_circles[$];
	int      mismatches;
	int      idle_cycles;
	bit      hold_off;       // long receiver stall requested by a test
	bit      sender_bursty;  // random gaps on the sender side

	// Integer square root, bit by bit, exact for 64-bit operands.
	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint clip24(longint q, inout bit clipped);
		longint hi, lo;
		hi = (longint'(1) <<< (ctf_pkg::CENTER_BITS - 1)) - 1;
		lo = -hi - 1;
		if (q > hi) begin
			clipped = 1;
			return hi;
		end
		if (q < lo) begin
			clipped = 1;
			return lo;
		end
		return q;
	endfunction

	// Circumcircle from the exact integer formula. SystemVerilog division of
	// signed longints truncates toward zero, which is what the block does.
	function automatic circle_t fit_circle(triple_t t);
		longint x1, y1, x2, y2, x3, y3, d, s1, s2, s3, nx, ny, cx, cy, sc, rs;
		longint unsigned ax, ay, r, d2, rmax;
		bit clipped, ok;
		circle_t c;
		x1 = t.x1; y1 = t.y1; x2 = t.x2; y2 = t.y2; x3 = t.x3; y3 = t.y3;
		rmax = (64'd1 << ctf_pkg::RADIUS_WIDTH) - 1;
		c = '0;
		clipped = 0;
		d = 2 * (x1 * (y2 - y3) - y1 * (x2 - x3) + x2 * y3 - x3 * y2);
		if (d == 0) begin
			c.col = 1'b1;
			return c;
		end
		s1 = x1 * x1 + y1 * y1;
		s2 = x2 * x2 + y2 * y2;
		s3 = x3 * x3 + y3 * y3;
		nx = s1 * (y2 - y3) + s2 * (y3 - y1) + s3 * (y1 - y2);
		ny = s1 * (x3 - x2) + s2 * (x1 - x3) + s3 * (x2 - x1);
		cx = clip24(nx / d, clipped);
		cy = clip24(ny / d, clipped);
		ax = (cx - x1) < 0 ? -(cx - x1) : (cx - x1);
		ay = (cy - y1) < 0 ? -(cy - y1) : (cy - y1);
		if (ax > (64'd1 << ctf_pkg::RADIUS_WIDTH) || ay > (64'd1 << ctf_pkg::RADIUS_WIDTH)) begin
			r = rmax;
		end else begin
			d2 = ax * ax + ay * ay;
			if (d2 >= (64'd1 << (2 * ctf_pkg::RADIUS_WIDTH - 2 * ctf_pkg::RADIUS_FRAC_BITS)))
				r = rmax;
			else
				r = floor_sqrt(d2 << (2 * ctf_pkg::RADIUS_FRAC_BITS));
			if (r > rmax) r = rmax;
		end
		sc = longint'(1) << ctf_pkg::RADIUS_FRAC_BITS;
		rs = longint'(r);
		ok = r >= win_min && r <= win_max;
		ok = ok && cx * sc > rs && cy * sc > rs;
		ok = ok && cx * sc + rs < longint'(img_cols) * sc;
		ok = ok && cy * sc + rs < longint'(img_rows) * sc;
		c.cx  = cx[ctf_pkg::CENTER_BITS-1:0];
		c.cy  = cy[ctf_pkg::CENTER_BITS-1:0];
		c.r   = r[ctf_pkg::RADIUS_WIDTH-1:0];
		c.sat = clipped;
		c.acc = ok;
		return c;
	endfunction

	// Send one request, with a random gap before it when bursts are on.
	int burst_left;
	task automatic send_triple(triple_t t);
		if (sender_bursty) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 30);
				if ($urandom_range(0, 1)) begin
					pts.valid <= 1'b0;
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end
			end
			burst_left--;
		end
		pts.valid    <= 1'b1;
		pts.first_x  <= t.x1;
		pts.first_y  <= t.y1;
		pts.second_x <= t.x2;
		pts.second_y <= t.y2;
		pts.third_x  <= t.x3;
		pts.third_y  <= t.y3;
		do @(posedge clk); while (!pts.ready);
		// The prediction is made at acceptance, with the registers then in force.
		expected_circles.insert(expected_circles.size(), fit_circle(t));
	endtask

	task automatic send_pts(int a, int b, int c, int d, int e, int f);
		triple_t t;
		t = {10'(a), 10'(b), 10'(c), 10'(d), 10'(e), 10'(f)};
		send_triple(t);
	endtask

	// Wait until every expected result is back, plus the pipeline depth.
	task automatic drain;
		pts.valid <= 1'b0;
		while (expected_circles.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	task automatic write_reg(logic [ctf_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val[ctf_pkg::CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			ctf_pkg::REG_MIN_RADIUS: win_min = val[ctf_pkg::RADIUS_REG_W-1:0];
			ctf_pkg::REG_MAX_RADIUS: win_max = val[ctf_pkg::RADIUS_REG_W-1:0];
			ctf_pkg::REG_IMAGE_COLS: img_cols = val[ctf_pkg::SIZE_REG_W-1:0];
			ctf_pkg::REG_IMAGE_ROWS: img_rows = val[ctf_pkg::SIZE_REG_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(int unsigned mn, int unsigned mx, int unsigned c, int unsigned r);
		write_reg(ctf_pkg::REG_MIN_RADIUS, mn);
		write_reg(ctf_pkg::REG_MAX_RADIUS, mx);
		write_reg(ctf_pkg::REG_IMAGE_COLS, c);
		write_reg(ctf_pkg::REG_IMAGE_ROWS, r);
		cfg.valid <= 1'b0;
	endtask

	// A small circle drawn around a random center, so that the window and the
	// inside test actually see hits.
	function automatic triple_t near_circle();
		triple_t t;
		int cx, cy, rr;
		cx = $urandom_range(0, 1023);
		cy = $urandom_range(0, 1023);
		rr = $urandom_range(1, 40);
		t.x1 = 10'(cx + rr);
		t.y1 = 10'(cy);
		t.x2 = 10'(cx - rr);
		t.y2 = 10'(cy + $urandom_range(0, 3));
		t.x3 = 10'(cx + $urandom_range(0, 3));
		t.y3 = 10'(cy + rr);
		return t;
	endfunction

	task automatic test_directed;
		send_pts(0, 0, 0, 0, 0, 0);               // all points equal
		send_pts(0, 0, 5, 5, 1023, 1023);         // collinear diagonal
		send_pts(10, 10, 20, 10, 30, 10);         // collinear row
		send_pts(100, 100, 106, 100, 100, 106);   // radius near window
		send_pts(100, 100, 116, 100, 100, 116);
		send_pts(0, 0, 1023, 0, 0, 1023);
		send_pts(1023, 1023, 0, 1023, 1023, 0);
		send_pts(0, 0, 1, 0, 1023, 1);            // nearly collinear, far center
		send_pts(0, 0, 1023, 1, 1022, 1);         // huge center, still inside the clip range
		send_pts(0, 1023, 1023, 1022, 1, 1023);
		send_pts(512, 512, 513, 512, 512, 513);
		send_pts(1023, 0, 0, 1023, 1023, 1023);
		send_pts(5, 0, 0, 5, 10, 5);              // touches the image edge
		send_pts(1018, 1018, 1023, 1013, 1013, 1013);
		send_pts(0, 1, 1, 0, 1023, 1022);
		send_pts(1023, 1023, 1022, 1023, 1023, 1022);
		drain();
	endtask

	task automatic test_random(int n);
		triple_t t;
		repeat (n) begin
			if ($urandom_range(0, 9) < 6)
				t = near_circle();
			else if ($urandom_range(0, 9) == 0)
				t = {10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom), 20'd0} |
					{40'd0, 10'($urandom), 10'($urandom)};
			else
				t = triple_t'(60'({$urandom, $urandom}));
			send_triple(t);
		end
		drain();
	endtask

	// The receiver stops for a long stretch while the sender keeps offering,
	// so the pipeline fills and pts.ready must drop.
	task automatic test_backpressure;
		hold_off = 1'b1;
		sender_bursty = 1'b0;
		repeat (120) send_triple(near_circle());
		sender_bursty = 1'b1;
		drain();
	endtask

	// Receiver: stalls on its own pattern, or holds off for a long counted stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			circle.ready <= 1'b0;
		end else if (hold_off) begin
			circle.ready <= 1'b0;
		end else begin
			circle.ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
		end
	end

	int stall_count;
	always @(posedge clk) begin
		if (hold_off) begin
			stall_count++;
			if (stall_count >= 400) begin
				hold_off = 1'b0;
				stall_count = 0;
			end
		end
	end

	// Result checker: compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		circle_t want;
		if (arst_n && circle.valid && circle.ready) begin
			if (expected_circles.size() == 0) begin
				$error("result with no request waiting");
				mismatches++;
			end else begin
				want = expected_circles.pop_front();
				if (circle.center_x !== want.cx) begin
					$error("center_x expected %0d got %0d", want.cx, circle.center_x);
					mismatches++;
				end
				if (circle.center_y !== want.cy) begin
					$error("center_y expected %0d got %0d", want.cy, circle.center_y);
					mismatches++;
				end
				if (circle.radius_q4 !== want.r) begin
					$error("radius_q4 expected %0d got %0d", want.r, circle.radius_q4);
					mismatches++;
				end
				if (circle.collinear !== want.col) begin
					$error("collinear expected %0d got %0d", want.col, circle.collinear);
					mismatches++;
				end
				if (circle.saturated !== want.sat) begin
					$error("saturated expected %0d got %0d", want.sat, circle.saturated);
					mismatches++;
				end
				if (circle.accepted !== want.acc) begin
					$error("accepted expected %0d got %0d", want.acc, circle.accepted);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on cycles with no transfer on any channel.
	always @(posedge clk) begin
		if ((pts.valid && pts.ready) || (circle.valid && circle.ready) ||
				(cfg.valid && cfg.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		pts.valid = 1'b0;
		{pts.first_x, pts.first_y, pts.second_x, pts.second_y, pts.third_x, pts.third_y} = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		mismatches = 0;
		idle_cycles = 0;
		hold_off = 1'b0;
		stall_count = 0;
		sender_bursty = 1'b1;
		burst_left = 0;
		win_min = ctf_pkg::MIN_RADIUS_RESET;
		win_max = ctf_pkg::MAX_RADIUS_RESET;
		img_cols = ctf_pkg::IMAGE_SIZE_RESET;
		img_rows = ctf_pkg::IMAGE_SIZE_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values first, then a range of windows and image sizes.
		test_directed();
		test_random(150);
		set_config(0, 65535, 1024, 1024);
		test_directed();
		test_random(150);
		set_config(16, 640, 640, 480);
		test_random(150);
		test_backpressure();
		set_config(65535, 0, 1, 1);      // inverted window, tiny image
		test_directed();
		test_random(100);
		set_config(0, 65535, 0, 0);      // zero image size
		test_random(50);
		set_config(32, 400, 2047, 1500);
		test_random(100);
		set_config(21845, 43690, 1365, 682);
		test_random(50);

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[filelist.f]
hdl/ctf_pkg.sv
hdl/ctf_if.sv
hdl/ctf_div.sv
hdl/ctf_isqrt.sv
hdl/three_point_circle_fit.sv
hdl/ctf_checker.sv
sim/tb_top.sv
